// ===== rtl/tim_image_stream_decoder_assert.svh =====
// Assertion macros used by the checker file of the TIM stream decoder.
`ifndef TIM_IMAGE_STREAM_DECODER_ASSERT_SVH
`define TIM_IMAGE_STREAM_DECODER_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define TIMDEC_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TIMDEC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TIMDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/timdec_pkg.sv =====
// Types, constants and codes shared by the TIM stream decoder files.
package timdec_pkg;

    localparam int LARGE_TABLE_ENTRIES = 256;
    localparam int SMALL_TABLE_ENTRIES = 16;

    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;
    // must stay a power of two: pointers wrap naturally
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int BC_W    = 34;
    localparam int COL_W   = 18;
    localparam int ROW_W   = 16;
    localparam int FIELD_W = 16;

    localparam logic [7:0] TIM_ID     = 8'h10;
    localparam logic [7:0] TYPE_4BIT  = 8'h08;
    localparam logic [7:0] TYPE_8BIT  = 8'h09;
    localparam logic [7:0] TYPE_16BIT = 8'h02;
    localparam logic [7:0] TYPE_24BIT = 8'h03;

    localparam int HEADER_LEN    = 8;
    localparam int TYPE_POS      = 4;
    localparam int BLOCK_HDR_LEN = 12;
    localparam logic [3:0] POS_A_LO = 4'd8;
    localparam logic [3:0] POS_A_HI = 4'd9;
    localparam logic [3:0] POS_B_LO = 4'd10;
    localparam logic [3:0] POS_B_HI = 4'd11;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CLUT_HDR,
        PH_ENTRIES,
        PH_SKIP,
        PH_IMG_HDR,
        PH_PIXELS,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef enum logic [1:0] {
        FMT_4BIT,
        FMT_8BIT,
        FMT_16BIT
    } fmt_t;

    typedef enum logic [2:0] {
        KIND_SIZE,
        KIND_PALETTE,
        KIND_INDEX,
        KIND_RGB,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NOT_TIM,
        ERR_24BPP,
        ERR_UNKNOWN_TYPE,
        ERR_SHORT_DATA
    } err_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        index_value;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        err_t              error_code;
        logic              last_of_run;
        logic              last_pixel;
    } result_t;

    // results of one decoded byte, handed from the core to the queue
    typedef struct packed {
        logic                              write;
        logic [RES_CNT_W-1:0]              count;
        result_t [MAX_RESULTS-1:0]         items;
    } batch_t;

endpackage

// ===== rtl/timdec_byte_if.sv =====
// Byte channel into the decoder: one file byte per item.
interface timdec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== rtl/timdec_result_if.sv =====
// Result channel out of the decoder: one decoded result per item.
interface timdec_result_if;
    logic                          valid;
    logic                          ready;
    timdec_pkg::kind_t             kind;
    logic [7:0]                    index_value;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic [timdec_pkg::COL_W-1:0]  column;
    logic [timdec_pkg::ROW_W-1:0]  row;
    timdec_pkg::err_t              error_code;
    logic                          last_of_run;
    logic                          last_pixel;

    modport source (
        output valid, output kind, output index_value, output red, output green,
        output blue, output column, output row, output error_code, output last_of_run,
        output last_pixel, input ready
    );
    modport sink (
        input valid, input kind, input index_value, input red, input green,
        input blue, input column, input row, input error_code, input last_of_run,
        input last_pixel, output ready
    );
endinterface

// ===== rtl/timdec_core.sv =====
// Decoder core: parse state and the combinational decode of one file byte.
module timdec_core #(
    parameter int LARGE_TABLE_ENTRIES = timdec_pkg::LARGE_TABLE_ENTRIES,
    parameter int SMALL_TABLE_ENTRIES = timdec_pkg::SMALL_TABLE_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,
    output timdec_pkg::batch_t batch
);

    localparam int BC_W  = timdec_pkg::BC_W;
    localparam int COL_W = timdec_pkg::COL_W;
    localparam int ROW_W = timdec_pkg::ROW_W;
    localparam int FW    = timdec_pkg::FIELD_W;
    localparam int MR    = timdec_pkg::MAX_RESULTS;
    localparam int RCW   = timdec_pkg::RES_CNT_W;

    localparam logic [BC_W-1:0] SMALL_LAST = BC_W'(2 * SMALL_TABLE_ENTRIES - 1);
    localparam logic [BC_W-1:0] LARGE_LAST = BC_W'(2 * LARGE_TABLE_ENTRIES - 1);
    localparam logic [BC_W-1:0] HDR_LAST   = BC_W'(timdec_pkg::HEADER_LEN - 1);
    localparam logic [BC_W-1:0] BLK_LAST   = BC_W'(timdec_pkg::BLOCK_HDR_LEN - 1);
    localparam logic [BC_W-1:0] TYPE_AT    = BC_W'(timdec_pkg::TYPE_POS);

    function automatic timdec_pkg::result_t make_result(
        input timdec_pkg::kind_t k,
        input logic [7:0]        idx,
        input logic [15:0]       word,
        input logic [COL_W-1:0]  col,
        input logic [ROW_W-1:0]  row,
        input timdec_pkg::err_t  err,
        input logic              lastpix
    );
        timdec_pkg::result_t r;
        r.kind        = k;
        r.index_value = idx;
        r.red         = {word[4:0], 3'b000};
        r.green       = {word[9:5], 3'b000};
        r.blue        = {word[14:10], 3'b000};
        r.column      = col;
        r.row         = row;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        r.last_pixel  = lastpix;
        return r;
    endfunction

    timdec_pkg::phase_t phase_reg, phase_next, step_phase;
    timdec_pkg::fmt_t   format_reg, format_next;
    logic [BC_W-1:0]    byte_count_reg, byte_count_next;
    logic [FW-1:0]      color_count_reg, color_count_next;
    logic [FW-1:0]      palette_count_reg, palette_count_next;
    logic [COL_W-1:0]   image_width_reg, image_width_next;
    logic [ROW_W-1:0]   image_height_reg, image_height_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [7:0]         held_low_reg, held_low_next;
    logic [31:0]        skip_half_reg;

    // header checks
    logic               bad_id, type_pos, type_known, hdr_fail, hdr_last, blk_last;
    timdec_pkg::fmt_t   type_fmt;
    timdec_pkg::err_t   type_err, hdr_err;

    // table and skip
    logic               entries_last, slot_shown, skip_none, skip_last;
    logic [7:0]         slot;
    logic [BC_W-1:0]    skip_bytes;
    logic [3:0]         pos;

    // image size at end of image header
    logic [COL_W-1:0]   size_width;
    logic [ROW_W-1:0]   size_height;
    logic               size_empty;

    // two chained pixel positions
    logic [COL_W:0]     a_col_inc, b_col_inc;
    logic [ROW_W:0]     a_row_inc, b_row_inc;
    logic               a_wrap, a_last, a_done, b_wrap, b_last, b_done, pixel_done;
    logic [COL_W-1:0]   a_col_next, b_col_next;
    logic [ROW_W-1:0]   a_row_next, b_row_next;

    timdec_pkg::result_t [MR-1:0] items;
    logic [RCW-1:0]               n;

    assign pos      = byte_count_reg[3:0];
    assign bad_id   = (byte_count_reg == '0) && (data_byte != timdec_pkg::TIM_ID);
    assign type_pos = (byte_count_reg == TYPE_AT);
    assign hdr_fail = bad_id || (type_pos && !type_known);
    assign hdr_err  = bad_id ? timdec_pkg::ERR_NOT_TIM : type_err;
    assign hdr_last = (byte_count_reg == HDR_LAST);
    assign blk_last = (byte_count_reg == BLK_LAST);

    always_comb
    begin
        type_known = 1'b1;
        type_fmt   = timdec_pkg::FMT_4BIT;
        type_err   = timdec_pkg::ERR_UNKNOWN_TYPE;
        unique case (data_byte)
            timdec_pkg::TYPE_4BIT:  type_fmt = timdec_pkg::FMT_4BIT;
            timdec_pkg::TYPE_8BIT:  type_fmt = timdec_pkg::FMT_8BIT;
            timdec_pkg::TYPE_16BIT: type_fmt = timdec_pkg::FMT_16BIT;
            timdec_pkg::TYPE_24BIT:
            begin
                type_known = 1'b0;
                type_err   = timdec_pkg::ERR_24BPP;
            end
            default:
            begin
                type_known = 1'b0;
                type_err   = timdec_pkg::ERR_UNKNOWN_TYPE;
            end
        endcase
    end

    assign entries_last = (format_reg == timdec_pkg::FMT_4BIT) ?
                          (byte_count_reg == SMALL_LAST) : (byte_count_reg == LARGE_LAST);
    assign slot         = byte_count_reg[8:1];
    assign slot_shown   = ({8'b0, slot} < color_count_reg);
    assign skip_bytes   = {1'b0, skip_half_reg, 1'b0};
    assign skip_none    = (skip_half_reg == '0);
    assign skip_last    = (byte_count_reg[BC_W-1:1] == '0);

    // extra palettes: (palettes - 1) * colors halfwords, settled long before the table ends
    always_ff @(posedge clk)
    begin
        if (palette_count_reg >= 16'd2)
            skip_half_reg <= {16'b0, palette_count_reg - 16'd1} * {16'b0, color_count_reg};
        else
            skip_half_reg <= '0;
    end

    always_comb
    begin
        case (format_reg)
            timdec_pkg::FMT_4BIT:  size_width = {image_width_reg[15:0], 2'b00};
            timdec_pkg::FMT_8BIT:  size_width = {1'b0, image_width_reg[15:0], 1'b0};
            default:               size_width = {2'b00, image_width_reg[15:0]};
        endcase
    end
    assign size_height = {data_byte, image_height_reg[7:0]};
    assign size_empty  = (size_width == '0) || (size_height == '0);

    assign a_col_inc  = {1'b0, column_reg} + 1'b1;
    assign a_row_inc  = {1'b0, row_reg} + 1'b1;
    assign a_wrap     = (a_col_inc >= {1'b0, image_width_reg});
    assign a_last     = (a_col_inc == {1'b0, image_width_reg}) &&
                        (a_row_inc == {1'b0, image_height_reg});
    assign a_done     = a_last || (a_wrap && (a_row_inc[ROW_W-1:0] == '0));
    assign a_col_next = a_wrap ? '0 : a_col_inc[COL_W-1:0];
    assign a_row_next = a_wrap ? a_row_inc[ROW_W-1:0] : row_reg;

    assign b_col_inc  = {1'b0, a_col_next} + 1'b1;
    assign b_row_inc  = {1'b0, a_row_next} + 1'b1;
    assign b_wrap     = (b_col_inc >= {1'b0, image_width_reg});
    assign b_last     = (b_col_inc == {1'b0, image_width_reg}) &&
                        (b_row_inc == {1'b0, image_height_reg});
    assign b_done     = b_last || (b_wrap && (b_row_inc[ROW_W-1:0] == '0));
    assign b_col_next = b_wrap ? '0 : b_col_inc[COL_W-1:0];
    assign b_row_next = b_wrap ? b_row_inc[ROW_W-1:0] : a_row_next;

    always_comb
    begin
        if (format_reg == timdec_pkg::FMT_16BIT)
            pixel_done = (byte_count_reg != '0) && a_done;
        else
            pixel_done = a_done || ((format_reg == timdec_pkg::FMT_4BIT) && b_done);
    end

    // next state
    always_comb
    begin
        step_phase = phase_reg;
        unique case (phase_reg)
            timdec_pkg::PH_HEADER:
            begin
                if (hdr_fail)
                    step_phase = timdec_pkg::PH_FAILED;
                else if (hdr_last)
                    step_phase = (format_reg == timdec_pkg::FMT_16BIT) ?
                                 timdec_pkg::PH_IMG_HDR : timdec_pkg::PH_CLUT_HDR;
            end
            timdec_pkg::PH_CLUT_HDR:
            begin
                if (blk_last)
                    step_phase = timdec_pkg::PH_ENTRIES;
            end
            timdec_pkg::PH_ENTRIES:
            begin
                if (entries_last)
                    step_phase = skip_none ? timdec_pkg::PH_IMG_HDR : timdec_pkg::PH_SKIP;
            end
            timdec_pkg::PH_SKIP:
            begin
                if (skip_last)
                    step_phase = timdec_pkg::PH_IMG_HDR;
            end
            timdec_pkg::PH_IMG_HDR:
            begin
                if (blk_last)
                    step_phase = size_empty ? timdec_pkg::PH_DONE : timdec_pkg::PH_PIXELS;
            end
            timdec_pkg::PH_PIXELS:
            begin
                if (pixel_done)
                    step_phase = timdec_pkg::PH_DONE;
            end
            default:
                step_phase = phase_reg;
        endcase

        if (!step)
            phase_next = phase_reg;
        else if (end_of_stream)
            phase_next = timdec_pkg::PH_HEADER;
        else
            phase_next = step_phase;
    end

    // results and datapath next values
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        format_next        = format_reg;
        color_count_next   = color_count_reg;
        palette_count_next = palette_count_reg;
        image_width_next   = image_width_reg;
        image_height_next  = image_height_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        held_low_next      = held_low_reg;
        n                  = '0;
        for (int i = 0; i < MR; i++)
            items[i] = make_result(timdec_pkg::KIND_SIZE, 8'h00, 16'h0000, '0, '0,
                                   timdec_pkg::ERR_NOT_TIM, 1'b0);

        unique case (phase_reg)
            timdec_pkg::PH_HEADER:
            begin
                if (hdr_fail)
                begin
                    items[0] = make_result(timdec_pkg::KIND_ERROR, 8'h00, 16'h0000, '0, '0,
                                           hdr_err, 1'b0);
                    n = 2'd1;
                end
                else
                begin
                    if (type_pos)
                        format_next = type_fmt;
                    byte_count_next = hdr_last ? '0 : byte_count_reg + 1'b1;
                end
            end
            timdec_pkg::PH_CLUT_HDR:
            begin
                case (pos)
                    timdec_pkg::POS_A_LO: color_count_next = {color_count_reg[15:8], data_byte};
                    timdec_pkg::POS_A_HI: color_count_next = {data_byte, color_count_reg[7:0]};
                    timdec_pkg::POS_B_LO:
                        palette_count_next = {palette_count_reg[15:8], data_byte};
                    timdec_pkg::POS_B_HI:
                        palette_count_next = {data_byte, palette_count_reg[7:0]};
                    default: ;
                endcase
                byte_count_next = blk_last ? '0 : byte_count_reg + 1'b1;
            end
            timdec_pkg::PH_ENTRIES:
            begin
                if (!byte_count_reg[0])
                    held_low_next = data_byte;
                else if (slot_shown)
                begin
                    items[0] = make_result(timdec_pkg::KIND_PALETTE, slot,
                                           {data_byte, held_low_reg}, '0, '0,
                                           timdec_pkg::ERR_NOT_TIM, 1'b0);
                    n = 2'd1;
                end
                byte_count_next = entries_last ? skip_bytes : byte_count_reg + 1'b1;
            end
            timdec_pkg::PH_SKIP:
            begin
                byte_count_next = (byte_count_reg == '0) ? '0 : byte_count_reg - 1'b1;
            end
            timdec_pkg::PH_IMG_HDR:
            begin
                case (pos)
                    timdec_pkg::POS_A_LO:
                        image_width_next = {2'b00, image_width_reg[15:8], data_byte};
                    timdec_pkg::POS_A_HI:
                        image_width_next = {2'b00, data_byte, image_width_reg[7:0]};
                    timdec_pkg::POS_B_LO:
                        image_height_next = {image_height_reg[15:8], data_byte};
                    timdec_pkg::POS_B_HI:
                        image_height_next = {data_byte, image_height_reg[7:0]};
                    default: ;
                endcase
                if (blk_last)
                begin
                    image_width_next  = size_width;
                    image_height_next = size_height;
                    column_next       = '0;
                    row_next          = '0;
                    byte_count_next   = '0;
                    items[0] = make_result(timdec_pkg::KIND_SIZE, 8'h00, 16'h0000,
                                           size_width, size_height,
                                           timdec_pkg::ERR_NOT_TIM, 1'b0);
                    n = 2'd1;
                end
                else
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
            end
            timdec_pkg::PH_PIXELS:
            begin
                if (format_reg == timdec_pkg::FMT_16BIT)
                begin
                    if (byte_count_reg == '0)
                    begin
                        held_low_next   = data_byte;
                        byte_count_next = BC_W'(1);
                    end
                    else
                    begin
                        byte_count_next = '0;
                        items[0] = make_result(timdec_pkg::KIND_RGB, 8'h00,
                                               {data_byte, held_low_reg}, column_reg, row_reg,
                                               timdec_pkg::ERR_NOT_TIM, a_last);
                        n           = 2'd1;
                        column_next = a_col_next;
                        row_next    = a_row_next;
                    end
                end
                else
                begin
                    // 4-bit data: low nibble is the left pixel
                    items[0] = make_result(timdec_pkg::KIND_INDEX,
                                           (format_reg == timdec_pkg::FMT_4BIT) ?
                                           {4'h0, data_byte[3:0]} : data_byte,
                                           16'h0000, column_reg, row_reg,
                                           timdec_pkg::ERR_NOT_TIM, a_last);
                    n           = 2'd1;
                    column_next = a_col_next;
                    row_next    = a_row_next;
                    if ((format_reg == timdec_pkg::FMT_4BIT) && !a_done)
                    begin
                        items[1] = make_result(timdec_pkg::KIND_INDEX, {4'h0, data_byte[7:4]},
                                               16'h0000, a_col_next, a_row_next,
                                               timdec_pkg::ERR_NOT_TIM, b_last);
                        n           = 2'd2;
                        column_next = b_col_next;
                        row_next    = b_row_next;
                    end
                end
            end
            default: ;
        endcase

        if (end_of_stream)
        begin
            if ((step_phase != timdec_pkg::PH_DONE) && (step_phase != timdec_pkg::PH_FAILED))
            begin
                items[n] = make_result(timdec_pkg::KIND_ERROR, 8'h00, 16'h0000, '0, '0,
                                       timdec_pkg::ERR_SHORT_DATA, 1'b0);
                n = n + 1'b1;
            end
            byte_count_next    = '0;
            format_next        = timdec_pkg::FMT_4BIT;
            color_count_next   = '0;
            palette_count_next = '0;
            image_width_next   = '0;
            image_height_next  = '0;
            column_next        = '0;
            row_next           = '0;
            held_low_next      = '0;
        end

        if (n != '0)
            items[n - 1'b1].last_of_run = 1'b1;
    end

    assign batch.write = step;
    assign batch.count = n;
    assign batch.items = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= timdec_pkg::PH_HEADER;
            byte_count_reg    <= '0;
            format_reg        <= timdec_pkg::FMT_4BIT;
            color_count_reg   <= '0;
            palette_count_reg <= '0;
            image_width_reg   <= '0;
            image_height_reg  <= '0;
            column_reg        <= '0;
            row_reg           <= '0;
            held_low_reg      <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (step)
            begin
                byte_count_reg    <= byte_count_next;
                format_reg        <= format_next;
                color_count_reg   <= color_count_next;
                palette_count_reg <= palette_count_next;
                image_width_reg   <= image_width_next;
                image_height_reg  <= image_height_next;
                column_reg        <= column_next;
                row_reg           <= row_next;
                held_low_reg      <= held_low_next;
            end
        end
    end

endmodule

// ===== rtl/timdec_queue.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle while the head is taken.
module timdec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  timdec_pkg::batch_t  batch,
    input  logic                head_taken,
    output logic                room,
    output logic                head_valid,
    output timdec_pkg::result_t head
);

    localparam int PW = timdec_pkg::QPTR_W;
    localparam int CW = timdec_pkg::QPTR_W + 1;
    localparam logic [CW-1:0] ROOM_LIMIT =
        CW'(timdec_pkg::QUEUE_DEPTH - timdec_pkg::MAX_RESULTS);

    timdec_pkg::result_t q_reg [timdec_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       add_count;
    logic                pop;

    assign add_count   = batch.write ? CW'(batch.count) : '0;
    assign pop         = head_taken && head_valid;
    assign wr_ptr_next = wr_ptr_reg + PW'(add_count);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + add_count - CW'(pop);

    assign room       = (count_reg <= ROOM_LIMIT);
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < timdec_pkg::MAX_RESULTS; i++)
        begin
            if (batch.write && (i < int'(batch.count)))
                q_reg[wr_ptr_reg + PW'(i)] <= batch.items[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tim_image_stream_decoder.sv =====
// TIM image stream decoder top level: input register, decode core, result queue.
//
// byte_stream takes the file one byte per item; end_of_stream marks the last byte.
// result_stream gives image size, palette entries, pixels and errors, one per item,
// in file order; last_of_run marks the last result caused by one byte.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// An accepted byte is held in the input register until the queue has room.
// Throughput: one byte per cycle while each byte yields at most one result and
// results are taken as they come; 4-bit pixel bytes yield two, so their rate is
// bounded by the one-result-per-cycle output port. A byte ending a 4-bit image
// early with end_of_stream can yield three results.
// The input register moves a byte into the decode core only while the 8-entry
// result queue has room for three results, so a stalled receiver fills the queue
// and then holds byte_stream.ready low; nothing is dropped.
// After end_of_stream the parser returns to its reset state and the next byte
// starts a new file. Reset (rst_n low) clears the parser, empties the queue and
// the input register; no clearing pass is needed.
module tim_image_stream_decoder #(
    parameter int LARGE_TABLE_ENTRIES = timdec_pkg::LARGE_TABLE_ENTRIES,
    parameter int SMALL_TABLE_ENTRIES = timdec_pkg::SMALL_TABLE_ENTRIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    timdec_byte_if.sink            byte_stream,
    timdec_result_if.source        result_stream
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          byte_reg;
    logic                eos_reg;
    logic                accept, step, room, head_valid, head_taken;
    timdec_pkg::batch_t  batch;
    timdec_pkg::result_t head;

    assign step              = in_valid_reg && room;
    assign byte_stream.ready = !in_valid_reg || step;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign in_valid_next     = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_stream.data_byte;
            eos_reg  <= byte_stream.end_of_stream;
        end
    end

    timdec_core #(
        .LARGE_TABLE_ENTRIES (LARGE_TABLE_ENTRIES),
        .SMALL_TABLE_ENTRIES (SMALL_TABLE_ENTRIES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (byte_reg),
        .end_of_stream (eos_reg),
        .batch         (batch)
    );

    timdec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .head_taken (head_taken),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign head_taken                = result_stream.ready;
    assign result_stream.valid       = head_valid;
    assign result_stream.kind        = head.kind;
    assign result_stream.index_value = head.index_value;
    assign result_stream.red         = head.red;
    assign result_stream.green       = head.green;
    assign result_stream.blue        = head.blue;
    assign result_stream.column      = head.column;
    assign result_stream.row         = head.row;
    assign result_stream.error_code  = head.error_code;
    assign result_stream.last_of_run = head.last_of_run;
    assign result_stream.last_pixel  = head.last_pixel;

endmodule

// ===== rtl/timdec_checker.sv =====
// Port-level checks on the decoder result channel, bound to the top level.
`include "tim_image_stream_decoder_assert.svh"

module timdec_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input timdec_pkg::kind_t            kind,
    input logic [timdec_pkg::COL_W-1:0] column,
    input logic [timdec_pkg::ROW_W-1:0] row,
    input timdec_pkg::err_t             error_code,
    input logic                         last_of_run,
    input logic                         last_pixel
);

    // a waiting result keeps its kind, column and row
    `TIMDEC_ASSERT_NEXT(a_result_held, clk, rst_n, valid && !ready, valid && $stable(kind) && $stable(column) && $stable(row), "result changed while stalled")

    // an error always closes the results of its byte
    `TIMDEC_ASSERT_IMPLIES(a_error_closes, clk, rst_n, valid && (kind == timdec_pkg::KIND_ERROR), last_of_run, "error result not last of its byte")

    // error code is only carried by error results
    `TIMDEC_ASSERT_IMPLIES(a_code_only_on_error, clk, rst_n, valid && (kind != timdec_pkg::KIND_ERROR), error_code == timdec_pkg::ERR_NOT_TIM, "error code set on a non-error result")

    // only pixels can be the final pixel
    `TIMDEC_ASSERT_IMPLIES(a_last_pixel_kind, clk, rst_n, valid && last_pixel, (kind == timdec_pkg::KIND_INDEX) || (kind == timdec_pkg::KIND_RGB), "last pixel flag on a non-pixel result")

endmodule

bind tim_image_stream_decoder timdec_checker u_timdec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result_stream.valid),
    .ready       (result_stream.ready),
    .kind        (result_stream.kind),
    .column      (result_stream.column),
    .row         (result_stream.row),
    .error_code  (result_stream.error_code),
    .last_of_run (result_stream.last_of_run),
    .last_pixel  (result_stream.last_pixel)
);
